>>> rtl/core/dedup_ring_list_macros.svh
// assertion macros for the dedup ring list checker
// expects aclk and aresetn to be visible where a macro is used
`ifndef DEDUP_RING_LIST_MACROS_SVH
`define DEDUP_RING_LIST_MACROS_SVH

// same-cycle implication, off while in reset
`define DRL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define DRL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/drl_pkg.sv
// dedup ring list package: field widths, stream packing and command/status codes
// no dependencies
`timescale 1ns / 1ps

package drl_pkg;

    localparam int KEY_BITS  = 32;
    localparam int ROW_BITS  = 6;
    localparam int CNT_BITS  = 7;
    localparam int CMD_BITS  = 3;
    localparam int STAT_BITS = 2;

    // slave tdata: item_key, row_index, zero pad to 40 bits
    localparam int S_DATA_W = 40;
    // master tdata: key_out, row_out, evicted, entry_count, zero pad to 48 bits
    localparam int M_DATA_W = 48;
    localparam int M_ROW_LSB = KEY_BITS;
    localparam int M_EVICT_BIT = KEY_BITS + ROW_BITS;
    localparam int M_CNT_LSB = KEY_BITS + ROW_BITS + 1;
    localparam int M_PAD_W = M_DATA_W - M_CNT_LSB - CNT_BITS;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD    = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_READ   = 3'd3,
        CMD_FIND   = 3'd4
    } cmd_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISS    = 2'd3
    } status_t;

endpackage

>>> rtl/core/dedup_ring_list.sv
// dedup ring list top: bounded insertion-ordered key set in a ring, command sequencer
// depends on drl_pkg and drl_store
`timescale 1ns / 1ps

// channel   | dir | signals                      | content
// s_        | in  | s_tvalid/s_tready/tdata/tuser | command, key, row offset
// m_        | out | m_tvalid/m_tready/tdata/tuser | status, key, row, evicted, count
// cfg_      | in  | cfg_wr_en/cfg_wr_data         | wrap_when_full
//
// one command at a time; the key store has one read port walked one entry per cycle
// add, lookup, find: walk the stored entries; delete: walk, then shift the younger entries back
// read row and unknown commands do not walk the store; s_tready is low while a command runs
// a finished result waits in the output register, so the next command may start under stall
// reset clears pointer, occupancy and wrap mode; stored keys are not cleared

module dedup_ring_list #(
    parameter int DEPTH     = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,  // wrap_when_full
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [drl_pkg::S_DATA_W-1:0]  s_tdata,      // item_key, row_index
    input  logic [drl_pkg::CMD_BITS-1:0]  s_tuser,      // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [drl_pkg::M_DATA_W-1:0]  m_tdata,      // key_out, row_out, evicted, entry_count
    output logic [drl_pkg::STAT_BITS-1:0] m_tuser       // status
);

    import drl_pkg::*;

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (KEY_WIDTH < KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int AW = ((SW > ROW_BITS) ? SW : ROW_BITS) + 1;
    localparam int XW = (CW > ROW_BITS) ? CW : ROW_BITS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_READ  = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic              wrap_reg;
    logic [SW-1:0]     oldest_reg, oldest_next;
    logic [CW-1:0]     occ_reg, occ_next;
    cmd_t              cmd_reg, cmd_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [ROW_BITS-1:0] row_reg, row_next;

    // scan pipeline: issue stage and compare stage
    logic [CW-1:0]     iss_row_reg, iss_row_next;
    logic [SW-1:0]     iss_slot_reg, iss_slot_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]     cmp_row_reg, cmp_row_next;
    logic [SW-1:0]     cmp_slot_reg, cmp_slot_next;

    // delete shift pipeline
    logic [CW-1:0]     sh_row_reg, sh_row_next;
    logic [SW-1:0]     sh_dst_reg, sh_dst_next;
    logic [SW-1:0]     sh_src_reg, sh_src_next;
    logic              sh_pend_reg, sh_pend_next;
    logic [SW-1:0]     sh_wdst_reg, sh_wdst_next;

    status_t           res_status_reg, res_status_next;
    logic [KW-1:0]     res_key_reg, res_key_next;
    logic [ROW_BITS-1:0] res_row_reg, res_row_next;
    logic              res_evict_reg, res_evict_next;

    logic              m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [STAT_BITS-1:0] m_user_reg, m_user_next;

    logic              mem_we;
    logic [SW-1:0]     mem_waddr;
    logic [KW-1:0]     mem_wdata;
    logic [SW-1:0]     mem_raddr;
    logic [KW-1:0]     mem_rdata;

    logic              s_xfer;
    logic [ROW_BITS-1:0] s_row;
    logic [AW-1:0]     rd_sum;
    logic [SW-1:0]     rd_slot;
    logic              hit;
    logic              scan_end;
    logic              shift_more;
    logic              out_free;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == SW'(DEPTH - 1)) ? '0 : s + SW'(1);
    endfunction

    drl_store #(
        .DEPTH (DEPTH),
        .WIDTH (KW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign s_row    = s_tdata[KEY_BITS +: ROW_BITS];
    assign out_free = !m_valid_reg || m_tready;

    // slot of a row offset; only meaningful when the row is below occupancy
    assign rd_sum  = AW'(oldest_reg) + AW'(s_row);
    assign rd_slot = (rd_sum >= AW'(DEPTH)) ? SW'(rd_sum - AW'(DEPTH)) : SW'(rd_sum);

    assign hit        = cmp_vld_reg && (mem_rdata == key_reg);
    assign scan_end   = !cmp_vld_reg && (iss_row_reg == occ_reg);
    assign shift_more = ((CW + 1)'(sh_row_reg) + (CW + 1)'(1)) < (CW + 1)'(occ_reg);

    always_comb begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        occ_next        = occ_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        row_next        = row_reg;
        iss_row_next    = iss_row_reg;
        iss_slot_next   = iss_slot_reg;
        cmp_vld_next    = 1'b0;
        cmp_row_next    = cmp_row_reg;
        cmp_slot_next   = cmp_slot_reg;
        sh_row_next     = sh_row_reg;
        sh_dst_next     = sh_dst_reg;
        sh_src_next     = sh_src_reg;
        sh_pend_next    = 1'b0;
        sh_wdst_next    = sh_wdst_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_row_next    = res_row_reg;
        res_evict_next  = res_evict_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        mem_we          = 1'b0;
        mem_waddr       = iss_slot_reg;
        mem_wdata       = key_reg;
        mem_raddr       = iss_slot_reg;

        case (state_reg)
            S_IDLE: begin
                mem_raddr = rd_slot;
                if (s_xfer) begin
                    cmd_next        = cmd_t'(s_tuser);
                    key_next        = KW'(s_tdata[KEY_BITS-1:0]);
                    row_next        = s_row;
                    iss_row_next    = '0;
                    iss_slot_next   = oldest_reg;
                    res_status_next = ST_MISS;
                    res_key_next    = '0;
                    res_row_next    = '0;
                    res_evict_next  = 1'b0;
                    case (cmd_t'(s_tuser))
                        CMD_ADD, CMD_DELETE, CMD_LOOKUP, CMD_FIND: state_next = S_SCAN;
                        CMD_READ: state_next = S_READ;
                        default:  state_next = S_FIN;
                    endcase
                end
            end

            S_SCAN: begin
                if (iss_row_reg < occ_reg) begin
                    iss_row_next  = iss_row_reg + CW'(1);
                    iss_slot_next = next_slot(iss_slot_reg);
                    cmp_vld_next  = 1'b1;
                    cmp_row_next  = iss_row_reg;
                    cmp_slot_next = iss_slot_reg;
                end
                if (hit) begin
                    state_next = S_FIN;
                    case (cmd_reg)
                        CMD_ADD: res_status_next = ST_PRESENT;
                        CMD_DELETE: begin
                            sh_row_next = cmp_row_reg;
                            sh_dst_next = cmp_slot_reg;
                            sh_src_next = next_slot(cmp_slot_reg);
                            state_next  = S_SHIFT;
                        end
                        CMD_LOOKUP: begin
                            res_status_next = ST_DONE;
                            res_key_next    = key_reg;
                        end
                        CMD_FIND: begin
                            res_status_next = ST_DONE;
                            res_row_next    = ROW_BITS'(cmp_row_reg);
                        end
                        default: res_status_next = ST_MISS;
                    endcase
                end else if (scan_end) begin
                    state_next = S_FIN;
                    if (cmd_reg == CMD_ADD) begin
                        // after a full walk the issue slot sits just past the youngest entry
                        if (occ_reg < CW'(DEPTH)) begin
                            mem_we          = 1'b1;
                            mem_waddr       = iss_slot_reg;
                            occ_next        = occ_reg + CW'(1);
                            res_status_next = ST_DONE;
                        end else if (wrap_reg) begin
                            mem_we          = 1'b1;
                            mem_waddr       = oldest_reg;
                            oldest_next     = next_slot(oldest_reg);
                            res_status_next = ST_DONE;
                            res_evict_next  = 1'b1;
                        end else begin
                            res_status_next = ST_FULL;
                        end
                    end
                end
            end

            S_SHIFT: begin
                // read one slot ahead, write it one slot back on the next cycle
                if (sh_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = sh_wdst_reg;
                    mem_wdata = mem_rdata;
                end
                if (shift_more) begin
                    mem_raddr    = sh_src_reg;
                    sh_pend_next = 1'b1;
                    sh_wdst_next = sh_dst_reg;
                    sh_dst_next  = sh_src_reg;
                    sh_src_next  = next_slot(sh_src_reg);
                    sh_row_next  = sh_row_reg + CW'(1);
                end else if (!sh_pend_reg) begin
                    occ_next        = occ_reg - CW'(1);
                    res_status_next = ST_DONE;
                    state_next      = S_FIN;
                end
            end

            S_READ: begin
                if (XW'(row_reg) < XW'(occ_reg)) begin
                    res_status_next = ST_DONE;
                    res_key_next    = mem_rdata;
                end
                state_next = S_FIN;
            end

            S_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = {{M_PAD_W{1'b0}}, CNT_BITS'(occ_reg), res_evict_reg,
                                    res_row_reg, KEY_BITS'(res_key_reg)};
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wrap_reg    <= 1'b0;
            oldest_reg  <= '0;
            occ_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            sh_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            occ_reg     <= occ_next;
            cmp_vld_reg <= cmp_vld_next;
            sh_pend_reg <= sh_pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                wrap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        row_reg        <= row_next;
        iss_row_reg    <= iss_row_next;
        iss_slot_reg   <= iss_slot_next;
        cmp_row_reg    <= cmp_row_next;
        cmp_slot_reg   <= cmp_slot_next;
        sh_row_reg     <= sh_row_next;
        sh_dst_reg     <= sh_dst_next;
        sh_src_reg     <= sh_src_next;
        sh_wdst_reg    <= sh_wdst_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_row_reg    <= res_row_next;
        res_evict_reg  <= res_evict_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> rtl/core/drl_store.sv
// dedup ring list key store: one write port, one registered read port
// no package dependencies
`timescale 1ns / 1ps

module drl_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/drl_chk.sv
// dedup ring list port checker and its bind to the top level
// depends on drl_pkg and dedup_ring_list_macros.svh
`timescale 1ns / 1ps
`include "dedup_ring_list_macros.svh"

module drl_chk #(
    parameter int DEPTH = 64
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [drl_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [drl_pkg::STAT_BITS-1:0] m_tuser
);

    import drl_pkg::*;

    logic [CNT_BITS-1:0] cnt;
    logic                evict;
    logic                miss;

    assign cnt   = m_tdata[M_CNT_LSB +: CNT_BITS];
    assign evict = m_tdata[M_EVICT_BIT];
    assign miss  = (m_tuser == ST_MISS);

    // a stalled result holds
    `DRL_ASSERT_NXT(a_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

    // one command at a time
    `DRL_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready, "command taken while busy")

    `DRL_ASSERT_IMP(a_count, m_tvalid, (DEPTH > 127) || (int'(cnt) <= DEPTH),
        "entry count above depth")

    `DRL_ASSERT_IMP(a_evict, m_tvalid && evict, m_tuser == ST_DONE,
        "eviction without a completed add")

    `DRL_ASSERT_IMP(a_miss, m_tvalid && miss,
        (m_tdata[KEY_BITS-1:0] == '0) && (m_tdata[M_ROW_LSB +: ROW_BITS] == '0) && !evict,
        "miss carries nonzero key or row")

endmodule

bind dedup_ring_list drl_chk #(.DEPTH(DEPTH)) u_drl_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
